[src/stbs_pkg.sv]
// Shared types and constants for the sorted table binary search unit.
// No dependencies; imported by stbs_ctrl, stbs_datapath and the top level.
package stbs_pkg;

  localparam int unsigned DEPTH_DEF   = 1024;
  localparam int unsigned VALUE_W_DEF = 32;

  localparam int unsigned FIELD_W     = 32;
  localparam int unsigned ADDR_FLD_W  = 10;
  localparam int unsigned COUNT_W     = 11;
  localparam int unsigned MODE_W      = 2;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  localparam logic [MODE_W-1:0] MODE_EXACT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CEIL  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLOOR = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

  typedef struct packed {
    logic write;
    logic start;
    logic read;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic bounds_met;
    logic last;
    logic out_free;
  } sts_t;

endpackage

[src/stbs_ctrl.sv]
// Sequencer for the binary search unit: accepts transactions and steps probes.
// Depends on stbs_pkg; drives stbs_datapath through cmd_t / sts_t.
module stbs_ctrl
  import stbs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic kind_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PROBE,
    ST_CMP,
    ST_RESULT
  } state_e;

  state_e state_q;

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = (state_q != ST_IDLE);
    cmd_o.write = (state_q == ST_IDLE) && in_valid_i && (kind_i == KIND_WRITE);
    cmd_o.start = (state_q == ST_IDLE) && in_valid_i && (kind_i == KIND_SEARCH);
    cmd_o.read  = (state_q == ST_PROBE);
    cmd_o.step  = (state_q == ST_CMP);
    cmd_o.emit  = (state_q == ST_RESULT) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.start) state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          if (sts_i.skip || sts_i.bounds_met) state_q <= ST_RESULT;
          else state_q <= ST_PROBE;
        end
        ST_PROBE: begin
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (sts_i.last) state_q <= ST_RESULT;
          else state_q <= ST_PROBE;
        end
        ST_RESULT: begin
          if (sts_i.out_free) state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_search_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && kind_i == KIND_SEARCH) |=> in_stall_o)
    else $error("input accepted right after a search transaction");

endmodule

[src/stbs_datapath.sv]
// Table memory, search bounds, comparator and output register.
// Depends on stbs_pkg; controlled by stbs_ctrl.
module stbs_datapath
  import stbs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_W_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [COUNT_W-1:0]           cfg_wdata_i,
  input  logic [ADDR_FLD_W-1:0]        write_address_i,
  input  logic signed [FIELD_W-1:0]    write_value_i,
  input  logic signed [FIELD_W-1:0]    search_key_i,
  input  logic [MODE_W-1:0]            search_mode_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic [ADDR_FLD_W-1:0]        found_index_o,
  output logic                         valid_res_o,
  input  cmd_t                         cmd_i,
  output sts_t                         sts_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned BW = AW + 1;

  logic signed [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];

  logic [COUNT_W-1:0]            entry_count_q;
  logic signed [VALUE_WIDTH-1:0] key_q;
  logic signed [VALUE_WIDTH-1:0] rdata_q;
  logic [MODE_W-1:0]             mode_q;
  logic [BW-1:0]                 lo_q, hi_q, mid_q;
  logic [BW-1:0]                 lo_d, hi_d;
  logic [AW-1:0]                 fidx_q;
  logic                          found_q, skip_q;
  logic                          out_valid_q, valid_res_q;
  logic [ADDR_FLD_W-1:0]         found_index_q;

  logic [BW-1:0] n_cnt;
  logic [BW:0]   sum;
  logic [BW-1:0] mid;
  logic          lt, gt, hit;
  logic          res_valid;
  logic [ADDR_FLD_W-1:0] res_idx;

  always_comb begin
    if (32'(entry_count_q) > TABLE_DEPTH) n_cnt = BW'(TABLE_DEPTH);
    else n_cnt = BW'(entry_count_q);
  end

  always_comb begin
    sum = {1'b0, lo_q} + {1'b0, hi_q};
    case (mode_q)
      MODE_EXACT: mid = BW'((sum - 1'b1) >> 1);
      MODE_FLOOR: mid = BW'((sum + 1'b1) >> 1);
      default:    mid = BW'(sum >> 1);
    endcase
  end

  always_comb begin
    lt   = key_q < rdata_q;
    gt   = key_q > rdata_q;
    hit  = (mode_q == MODE_EXACT) && !lt && !gt;
    lo_d = lo_q;
    hi_d = hi_q;
    case (mode_q)
      MODE_EXACT: begin
        if (lt) hi_d = mid_q;
        else if (gt) lo_d = mid_q + 1'b1;
      end
      MODE_CEIL: begin
        if (!gt) hi_d = mid_q;
        else lo_d = mid_q + 1'b1;
      end
      MODE_FLOOR: begin
        if (!lt) lo_d = mid_q;
        else hi_d = mid_q - 1'b1;
      end
      default: begin
        lo_d = lo_q;
      end
    endcase
  end

  always_comb begin
    res_valid = 1'b0;
    res_idx   = '0;
    case (mode_q)
      MODE_EXACT: begin
        res_valid = found_q;
        res_idx   = found_q ? ADDR_FLD_W'(fidx_q) : '0;
      end
      MODE_CEIL: begin
        res_valid = 1'b1;
        res_idx   = ADDR_FLD_W'(hi_q);
      end
      MODE_FLOOR: begin
        res_valid = 1'b1;
        res_idx   = ADDR_FLD_W'(lo_q);
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
    if (skip_q) begin
      res_valid = 1'b0;
      res_idx   = '0;
    end
  end

  assign sts_o.skip       = skip_q;
  assign sts_o.bounds_met = lo_q >= hi_q;
  assign sts_o.last       = hit || (lo_d >= hi_d);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.write && (32'(write_address_i) < TABLE_DEPTH)) begin
      mem[AW'(write_address_i)] <= VALUE_WIDTH'(write_value_i);
    end
    if (cmd_i.read) begin
      rdata_q <= mem[AW'(mid)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      key_q  <= VALUE_WIDTH'(search_key_i);
      mode_q <= search_mode_i;
      lo_q   <= '0;
      hi_q   <= (search_mode_i == MODE_EXACT) ? n_cnt : n_cnt - 1'b1;
      skip_q <= (n_cnt == '0) || (search_mode_i == MODE_NONE);
    end else if (cmd_i.step) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
    if (cmd_i.read) mid_q <= mid;
    if (cmd_i.step && hit) fidx_q <= AW'(mid_q);
    if (cmd_i.emit) begin
      valid_res_q   <= res_valid;
      found_index_q <= res_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
      found_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) entry_count_q <= cfg_wdata_i;
      if (cmd_i.start) found_q <= 1'b0;
      else if (cmd_i.step && hit) found_q <= 1'b1;
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign valid_res_o   = valid_res_q;
  assign found_index_o = found_index_q;

  a_probe_open_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.read |-> (lo_q < hi_q))
    else $error("probe issued on an empty search range");

  a_mid_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.read |-> (mid >= lo_q && mid <= hi_q))
    else $error("probe midpoint outside search range");

  a_invalid_zero_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !valid_res_q) |-> (found_index_q == '0))
    else $error("invalid result carries a nonzero index");

endmodule

[src/sorted_table_binary_search_unit.sv]
// Sorted table binary search unit: top level.
// Depends on stbs_pkg, stbs_ctrl and stbs_datapath.
//
// Input channel (in_valid_i / in_stall_o) carries one transaction per item:
// kind_i = 0 writes write_value_i at write_address_i, kind_i = 1 searches for
// search_key_i with search_mode_i (exact, ceiling, floor, none). Writes finish in the
// accepting cycle and produce no result. Each search produces one result on
// the output channel (out_valid_o / out_stall_i): found_index_o, valid_res_o.
// cfg_we_i / cfg_wdata_i set the number of table entries in use; write it only
// while the unit is idle.
// Between acceptance and out_valid_o a search makes P probes, P being at most
// ceil(log2(n)) + 1 for n entries and 0 for an empty table or unused mode;
// each probe is a registered memory read followed by a compare and bound
// update. One search is in flight at a time; in_stall_o is high from the cycle
// after a search is accepted until its result is loaded into the output
// register. Writes can be accepted every cycle while no search is in flight.
// A stalled result holds in the output register and the unit waits before
// loading the next one. Reset clears the entry count and output valid; table
// contents are undefined until written.
module sorted_table_binary_search_unit
  import stbs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_W_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [COUNT_W-1:0]        cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      kind_i,
  input  logic [ADDR_FLD_W-1:0]     write_address_i,
  input  logic signed [FIELD_W-1:0] write_value_i,
  input  logic signed [FIELD_W-1:0] search_key_i,
  input  logic [MODE_W-1:0]         search_mode_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [ADDR_FLD_W-1:0]     found_index_o,
  output logic                      valid_res_o
);

  cmd_t cmd;
  sts_t sts;

  stbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (kind_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  stbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .write_address_i (write_address_i),
    .write_value_i   (write_value_i),
    .search_key_i    (search_key_i),
    .search_mode_i   (search_mode_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .found_index_o   (found_index_o),
    .valid_res_o     (valid_res_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule
